// ===== sv/longest_prefix_match_route_table_macros.svh =====
// Assertion helpers shared by the route table modules.
`ifndef LONGEST_PREFIX_MATCH_ROUTE_TABLE_MACROS_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_TABLE_MACROS_SVH

// Implication check that is disabled while reset is held.
`define LPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check that is disabled while reset is held.
`define LPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpm_pkg;
  localparam int Entries = 64;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROUTE = 2'd1,
    ST_DEL_MISS = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [7:0]  ifc;
    logic [31:0] hop;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  ifc;
    logic [31:0] hop;
    logic [5:0]  len;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } eng_state_t;

  function automatic logic [31:0] top_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      if (32 - b <= int'(len)) m[b] = 1'b1;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== sv/lpm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input stage: saturates the length and holds up to two commands for the engine.
module lpm_front import lpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_address,
  input  wire logic [5:0]  in_prefix_length,
  input  wire logic [7:0]  in_interface_id,
  input  wire logic [31:0] in_next_hop,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_take
);
  `include "longest_prefix_match_route_table_macros.svh"

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c_in;
  logic       wr, rd;

  always_comb begin
    c_in.op   = op_t'(in_operation);
    c_in.addr = in_address;
    c_in.len  = (in_prefix_length > 6'd32) ? 6'd32 : in_prefix_length;
    c_in.ifc  = in_interface_id;
    c_in.hop  = in_next_hop;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= c_in;
  end

  `LPM_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'd2, "front queue count out of range")
  `LPM_ASSERT_NXT(a_cnt_inc, wr && !rd, cnt_r == $past(cnt_r) + 2'd1, "front count lost a push")
  `LPM_ASSERT_IMP(a_len_sat, cmd_valid, cmd.len <= 6'd32, "unsaturated length queued")
endmodule
`default_nettype wire

// ===== sv/lpm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back part: table memory, one entry per cycle scan, one entry per cycle shift.
module lpm_engine import lpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_take,
  output logic             out_empty,
  output rsp_t             out_rsp,
  input  wire logic        pop
);
  `include "longest_prefix_match_route_table_macros.svh"

  localparam int RowW = 32 + 6 + 8 + 32;

  logic [RowW-1:0] mem [Entries];
  logic [RowW-1:0] rd_q;

  eng_state_t  st_r, st_nxt;
  cmd_t        c_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] k_r, k_nxt;     // entries left to scan / next shift source
  logic        pend_r, pend_nxt;   // read data in rd_q is valid (index k_r while scanning)
  logic [IdxW-1:0] pidx_r;
  rsp_t        best_r, best_nxt;
  logic        found_r, found_nxt;
  logic [IdxW-1:0] hit_r, hit_nxt;
  rsp_t        o_r;
  logic        ov_r, ov_nxt;

  logic        rd_en, wr_en;
  logic [IdxW-1:0] rd_a, wr_a;
  logic [RowW-1:0] wr_d;
  logic [31:0] e_pre, e_hop;
  logic [5:0]  e_len;
  logic [7:0]  e_ifc;
  logic        e_match;
  logic        ins_full;

  assign {e_pre, e_len, e_ifc, e_hop} = rd_q;
  assign e_match = ((c_r.addr ^ e_pre) & top_mask(e_len)) == 32'd0;
  assign ins_full = st_r == S_IDLE && cmd_valid && cmd.op == OP_INSERT &&
                    count_r == CntW'(Entries);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    if (rd_en) rd_q <= mem[rd_a];
  end

  assign out_empty = !ov_r;
  assign out_rsp   = o_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd_valid) begin
        if (cmd.op == OP_LOOKUP || cmd.op == OP_DELETE) st_nxt = S_SCAN;
        else st_nxt = S_DONE;
      end
      S_SCAN: if (k_r == '0 && !pend_r) begin
        if (c_r.op == OP_DELETE && found_r) st_nxt = S_SHIFT;
        else st_nxt = S_DONE;
      end else if (c_r.op == OP_DELETE && pend_r && e_len == c_r.len && e_match) begin
        st_nxt = S_SHIFT;
      end
      S_SHIFT: if (k_r >= count_r && !pend_r) st_nxt = S_DONE;
      S_DONE: if (!ov_r || pop) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_take  = 1'b0;
    count_nxt = count_r;
    k_nxt     = k_r;
    pend_nxt  = 1'b0;
    best_nxt  = best_r;
    found_nxt = found_r;
    hit_nxt   = hit_r;
    ov_nxt    = ov_r && !pop;
    rd_en     = 1'b0;
    rd_a      = '0;
    wr_en     = 1'b0;
    wr_a      = '0;
    wr_d      = rd_q;
    case (st_r)
      S_IDLE: begin
        cmd_take = cmd_valid;
        k_nxt    = count_r;
        best_nxt = '{status: ST_NO_ROUTE, ifc: '0, hop: '0, len: '0};
        found_nxt = 1'b0;
        if (cmd_valid && cmd.op == OP_INSERT) begin
          if (count_r == CntW'(Entries)) begin
            best_nxt.status = ST_FULL;
          end else begin
            wr_en = 1'b1;
            wr_a  = count_r[IdxW-1:0];
            wr_d  = {cmd.addr, cmd.len, cmd.ifc, cmd.hop};
            count_nxt = count_r + 1'b1;
            best_nxt.status = ST_OK;
          end
        end else if (cmd_valid && cmd.op == OP_DELETE) begin
          best_nxt.status = ST_DEL_MISS;
        end
      end
      S_SCAN: begin
        if (pend_r) begin
          if (c_r.op == OP_LOOKUP) begin
            if (e_match && e_len > best_r.len) begin
              best_nxt = '{status: ST_OK, ifc: e_ifc, hop: e_hop, len: e_len};
            end
          end else if (e_len == c_r.len && e_match) begin
            found_nxt = 1'b1;
            hit_nxt   = pidx_r;
          end
        end
        if (k_r != '0 && !(c_r.op == OP_DELETE && pend_r && e_len == c_r.len && e_match)) begin
          rd_en    = 1'b1;
          rd_a     = IdxW'(k_r - 1'b1);
          k_nxt    = k_r - 1'b1;
          pend_nxt = 1'b1;
        end
        if (st_nxt == S_SHIFT) begin
          k_nxt = found_nxt ? {1'b0, hit_nxt} + 1'b1 : k_r;
        end
      end
      S_SHIFT: begin
        // read entry k, then write it to k-1
        if (pend_r) begin
          wr_en = 1'b1;
          wr_a  = pidx_r;
        end
        if (k_r < count_r) begin
          rd_en    = 1'b1;
          rd_a     = k_r[IdxW-1:0];
          k_nxt    = k_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          count_nxt = count_r - 1'b1;
          best_nxt.status = ST_OK;
        end
      end
      S_DONE: begin
        if (!ov_r || pop) ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    best_r  <= best_nxt;
    found_r <= found_nxt;
    hit_r   <= hit_nxt;
    if (st_r == S_IDLE && cmd_valid) c_r <= cmd;
    if (st_r == S_SHIFT) pidx_r <= IdxW'(rd_a - 1'b1);
    else pidx_r <= rd_a;
    if (st_r == S_DONE && (!ov_r || pop)) o_r <= best_r;
  end

  `LPM_ASSERT_IMP(a_count_max, 1'b1, count_r <= CntW'(Entries), "entry count above depth")
  `LPM_ASSERT_NXT(a_full_keep, ins_full, count_r == CntW'(Entries), "full insert changed count")
  `LPM_ASSERT_IMP(a_hit_len, ov_r && o_r.status == ST_OK, o_r.len <= 6'd32, "bad match length")
  `LPM_ASSERT_IMP(a_take_idle, cmd_take, st_r == S_IDLE, "command taken while busy")
endmodule
`default_nettype wire

// ===== sv/longest_prefix_match_route_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// IPv4 longest prefix match route table.
// Input channel: push/full with in_operation (insert, lookup, delete),
// in_address, in_prefix_length, in_interface_id, in_next_hop. An item is
// taken when push is high and full is low; a two-entry queue in front lets
// up to two items wait while the engine works.
// Result channel: empty/pop; the oldest result sits on out_* while empty is
// low and leaves on pop. Exactly one result per item, in order.
// Operation: insert writes the table straight from idle; lookup reads all N
// stored routes, one table memory read per cycle; delete scans newest to
// oldest until a hit, then shifts the younger routes down one per cycle.
// The table memory has a single read port, so each route is read in turn.
// The engine takes a new item only once the last result is registered.
// Reset empties the table, the front queue and the result register. A
// held result blocks the engine after its next item is finished; input
// still fills the front queue.
module longest_prefix_match_route_table import lpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_address,
  input  wire logic [5:0]  in_prefix_length,
  input  wire logic [7:0]  in_interface_id,
  input  wire logic [31:0] in_next_hop,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_status,
  output logic [7:0]       out_interface,
  output logic [31:0]      out_next_hop,
  output logic [5:0]       out_matched_length
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;
  rsp_t rsp;

  lpm_front u_front (
    .clk, .rst_n, .push, .full, .in_operation, .in_address, .in_prefix_length,
    .in_interface_id, .in_next_hop, .cmd_valid, .cmd, .cmd_take
  );

  lpm_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_empty(empty), .out_rsp(rsp), .pop
  );

  assign out_status         = rsp.status;
  assign out_interface      = rsp.ifc;
  assign out_next_hop       = rsp.hop;
  assign out_matched_length = rsp.len;
endmodule
`default_nettype wire

// ===== dv/lpm_route_checker.sv =====
`timescale 1ns / 1ps
module lpm_route_checker import lpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_length,
  input  logic [7:0]  in_interface_id,
  input  logic [31:0] in_next_hop,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_interface,
  input  logic [31:0] out_next_hop,
  input  logic [5:0]  out_matched_length,
  output int          error_count,
  output int          pending_count
);
  logic [31:0] route_prefix [Entries];
  logic [5:0]  route_len [Entries];
  logic [7:0]  route_ifc [Entries];
  logic [31:0] route_hop [Entries];
  int          route_count;
  rsp_t        expected_rsp_q[$];

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    if (len == 0) return 32'h0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic predict_route(input op_t op, input logic [31:0] addr,
                               input logic [5:0] len_in, input logic [7:0] ifc,
                               input logic [31:0] hop);
    rsp_t r;
    logic [5:0] len;
    int hit;
    len = (len_in > 32) ? 6'd32 : len_in;
    r = '{status: ST_NO_ROUTE, ifc: 8'd0, hop: 32'd0, len: 6'd0};
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (route_count >= Entries) begin
          r.status = ST_FULL;
        end else begin
          route_prefix[route_count] = addr;
          route_len[route_count] = len;
          route_ifc[route_count] = ifc;
          route_hop[route_count] = hop;
          route_count++;
          r.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        for (int k = route_count - 1; k >= 0; k--) begin
          if (((addr ^ route_prefix[k]) & prefix_mask(route_len[k])) == 0 &&
              route_len[k] > r.len) begin
            r.len = route_len[k];
            r.ifc = route_ifc[k];
            r.hop = route_hop[k];
          end
        end
        r.status = (r.len == 0) ? ST_NO_ROUTE : ST_OK;
      end
      OP_DELETE: begin
        for (int k = route_count - 1; k >= 0 && hit < 0; k--)
          if (route_len[k] == len &&
              ((addr ^ route_prefix[k]) & prefix_mask(route_len[k])) == 0)
            hit = k;
        if (hit >= 0) begin
          for (int i = hit; i + 1 < route_count; i++) begin
            route_prefix[i] = route_prefix[i + 1];
            route_len[i] = route_len[i + 1];
            route_ifc[i] = route_ifc[i + 1];
            route_hop[i] = route_hop[i + 1];
          end
          route_count--;
          r.status = ST_OK;
        end else begin
          r.status = ST_DEL_MISS;
        end
      end
      default: ;
    endcase
    expected_rsp_q.push_back(r);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      route_count = 0;
      error_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (push && !full)
        predict_route(op_t'(in_operation), in_address, in_prefix_length,
                      in_interface_id, in_next_hop);
      if (pop && !empty) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_status), 32'd0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_interface !== want.ifc) report_mismatch("interface", out_interface, want.ifc);
          if (out_next_hop !== want.hop) report_mismatch("next_hop", out_next_hop, want.hop);
          if (out_matched_length !== want.len)
            report_mismatch("length", out_matched_length, want.len);
        end
      end
    end
    pending_count = expected_rsp_q.size();
  end
endmodule

// ===== dv/tb_longest_prefix_match_route_table.sv =====
`timescale 1ns / 1ps
module tb_longest_prefix_match_route_table;
  import lpm_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        push = 0;
  logic        pop = 0;
  logic        full, empty;
  logic [1:0]  in_operation = OP_INSERT;
  logic [31:0] in_address = 0;
  logic [5:0]  in_prefix_length = 0;
  logic [7:0]  in_interface_id = 0;
  logic [31:0] in_next_hop = 0;
  logic [1:0]  out_status;
  logic [7:0]  out_interface;
  logic [31:0] out_next_hop;
  logic [5:0]  out_matched_length;
  int          error_count, pending_count;
  int          cycle_count = 0;
  bit          pop_stall_long = 0;
  logic [31:0] known_prefix [$];
  logic [5:0]  known_len [$];

  always #5 clk = ~clk;

  longest_prefix_match_route_table uut (.*);
  lpm_route_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random pop with short and occasional long stalls
  always @(posedge clk) begin
    if (!rst_n) pop <= 0;
    else if (pop_stall_long) pop <= ($urandom_range(0, 99) == 0);
    else pop <= ($urandom_range(0, 3) != 0);
  end
  always @(posedge clk) begin
    if ($urandom_range(0, 999) == 0) pop_stall_long <= 1;
    else if (pop_stall_long && $urandom_range(0, 199) == 0) pop_stall_long <= 0;
  end

  // push stays high between back to back items; it drops only before a gap
  task automatic send_item(input op_t op, input logic [31:0] addr, input logic [5:0] len,
                           input logic [7:0] ifc, input logic [31:0] hop);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    in_operation <= op;
    in_address <= addr;
    in_prefix_length <= len;
    in_interface_id <= ifc;
    in_next_hop <= hop;
    do @(posedge clk); while (full);
    if (op == OP_INSERT) begin
      known_prefix.push_back(addr);
      known_len.push_back(len);
    end
  endtask

  task automatic drain_all();
    push <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int pick, idx;
    logic [5:0] len;
    logic [31:0] addr;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_item(OP_LOOKUP, 32'h0A00_0001, 6'd0, 8'd0, 32'd0);
    send_item(OP_DELETE, 32'h0A00_0000, 6'd8, 8'd0, 32'd0);
    send_item(OP_INSERT, 32'h0000_0000, 6'd0, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h1234_5678, 6'd0, 8'd0, 32'd0);
    send_item(OP_INSERT, 32'h0A00_0000, 6'd8, 8'h01, 32'h0A00_00FE);
    send_item(OP_INSERT, 32'h0A01_0000, 6'd16, 8'h02, 32'h0A01_00FE);
    send_item(OP_INSERT, 32'h0A01_0000, 6'd16, 8'h03, 32'h0A01_00FD);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 8'h04, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0A01_0203, 6'd32, 8'h05, 32'h0);
    send_item(OP_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0, 32'd0);
    send_item(OP_LOOKUP, 32'h0A01_0204, 6'd0, 8'd0, 32'd0);
    send_item(OP_LOOKUP, 32'h0A02_0000, 6'd0, 8'd0, 32'd0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0, 32'd0);
    send_item(OP_NONE, 32'hFFFF_FFFF, 6'h3F, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_DELETE, 32'h0A01_FFFF, 6'd16, 8'd0, 32'd0);
    send_item(OP_LOOKUP, 32'h0A01_0001, 6'd0, 8'd0, 32'd0);
    send_item(OP_DELETE, 32'hFFFF_FFFF, 6'd33, 8'd0, 32'd0);
    send_item(OP_DELETE, 32'h0000_0000, 6'd0, 8'd0, 32'd0);
    send_item(OP_DELETE, 32'h0B00_0000, 6'd8, 8'd0, 32'd0);
    drain_all();
    // fill to the top and overflow
    for (int i = 0; i < Entries + 3; i++)
      send_item(OP_INSERT, $urandom, 6'($urandom_range(1, 32)), 8'($urandom), $urandom);
    send_item(OP_LOOKUP, $urandom, 6'd0, 8'd0, 32'd0);
    drain_all();
    for (int i = 0; i < 70; i++)
      send_item(OP_DELETE, known_prefix[known_prefix.size() - 1 - i % 10],
                6'($urandom_range(0, 32)), 8'd0, 32'd0);
    known_prefix.delete();
    known_len.delete();
    // random, biased toward addresses near stored routes
    for (int i = 0; i < 240; i++) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 32));
      addr = $urandom;
      if (known_prefix.size() > 0 && pick % 2 == 0) begin
        idx = $urandom_range(0, known_prefix.size() - 1);
        addr = known_prefix[idx] ^ ($urandom & ~(32'hFFFF_FFFF << $urandom_range(0, 31)));
        if (pick < 60) len = known_len[idx];
      end
      if (pick < 35) send_item(OP_INSERT, addr, len, 8'($urandom), $urandom);
      else if (pick < 75) send_item(OP_LOOKUP, addr, 6'($urandom), 8'($urandom), $urandom);
      else if (pick < 97) send_item(OP_DELETE, addr, len, 8'($urandom), $urandom);
      else send_item(OP_NONE, addr, len, 8'($urandom), $urandom);
      if (i == 120) drain_all();
    end
    drain_all();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
